FILE: sv/tpsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ---------------------------------------------------------------------------
package tpsd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // width and height registers as written
    localparam int DIM_W  = 13;
    // saturated sizes, able to hold the maximum itself
    localparam int WE_W   = $clog2(MAX_WIDTH) + 1;
    localparam int HE_W   = $clog2(MAX_HEIGHT) + 1;
    // raster cursors
    localparam int CX_W   = $clog2(MAX_WIDTH);
    localparam int CY_W   = $clog2(MAX_HEIGHT);
    // pixel count of the image and pixels given out so far
    localparam int TOT_W  = WE_W + HE_W;
    localparam int PE_W   = TOT_W - 1;
    localparam int ADDR_W = 26;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = DIM_W;
    localparam logic [CFG_AW-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RLE_ENABLE   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_X_REVERSE    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_Y_REVERSE    = 3'd5;

    // pixel formats
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    // input item kinds
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    // run-length header fields
    localparam int HDR_REPEAT_BIT = 7;
    localparam int HDR_COUNT_W    = 7;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RAW    = 2'd1,
        PH_REPEAT = 2'd2,
        PH_RUN    = 2'd3
    } t_phase;

    // one decoded result on its way to the address stage
    typedef struct packed {
        logic            pixel;
        logic            run_pending;
        logic            error;
        logic            done;
        logic [CX_W-1:0] col;
        logic [CY_W-1:0] row;
        logic [WE_W-1:0] width;
        logic            texel4;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
    } t_pix;

endpackage
`default_nettype wire

FILE: sv/tpsd_addr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tpsd_addr
// Texel byte address: (column + width * row) times 3 or 4 bytes, low bits
// kept. Zero for results that carry no pixel.
// ---------------------------------------------------------------------------
module tpsd_addr (
    input  var tpsd_pkg::t_pix             i_pix,
    output logic [tpsd_pkg::ADDR_W-1:0]    o_addr
);
    import tpsd_pkg::*;

    logic [WE_W+CY_W-1:0] row_base;
    logic [ADDR_W-1:0]    lin;
    logic [ADDR_W-1:0]    scaled;

    always_comb begin
        row_base = i_pix.width * i_pix.row;
        lin      = ADDR_W'(row_base) + ADDR_W'(i_pix.col);
        // 16- and 24-bit texels occupy 3 bytes, 32-bit texels 4
        if (i_pix.texel4) begin
            scaled = lin << 2;
        end else begin
            scaled = lin + (lin << 1);
        end
        o_addr = i_pix.pixel ? scaled : '0;
    end

endmodule
`default_nettype wire

FILE: sv/tga_pixel_stream_decoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Decodes TGA pixel data bytes (raw or run-length packets) into RGBA pixels
// with their texel byte addresses along a configurable raster walk.
// ---------------------------------------------------------------------------
// The block takes one transfer per clock: a file byte (tuser 0) or a pull of
// the next pixel of a pending repeat run (tuser 1), and gives exactly one
// result transfer for each, via the decode stage and output registers. Decode
// and raster cursor update happen in the accepting cycle, as does the image
// size product for end-of-image detection. The address multiply sits in the
// following stage, and an output register holds the result, so input is
// taken every cycle while the output side keeps up. The user writes
// configuration only between images or while no transfer is in flight; the
// block does not enforce this. New values act on the next accepted transfer.
// ---------------------------------------------------------------------------
module tga_pixel_stream_decoder (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    // configuration write port
    input  var logic                          i_cfg_we,
    input  var logic [tpsd_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  var logic [tpsd_pkg::CFG_DW-1:0]   i_cfg_wdata,
    // input stream
    input  var logic                          s_axis_tvalid,
    output logic                              s_axis_tready,
    input  var logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  var logic                          s_axis_tuser,  // [0] mode
    // result stream
    output logic                              m_axis_tvalid,
    input  var logic                          m_axis_tready,
    // [25:0] byte_address, [33:26] red, [41:34] green, [49:42] blue,
    // [57:50] alpha, [58] run_pending, [59] protocol_error, [63:60] zero
    output logic [63:0]                       m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] pixel_valid
    output logic                              m_axis_tlast   // image_done
);
    import tpsd_pkg::*;

    // configuration
    logic [1:0]       r_fmt;
    logic             r_rle;
    logic [DIM_W-1:0] r_img_w;
    logic [DIM_W-1:0] r_img_h;
    logic             r_xrev;
    logic             r_yrev;

    // decoder state
    t_phase                 r_phase,    n_phase;
    logic [HDR_COUNT_W-1:0] r_left,     n_left;
    logic [1:0]             r_bphase,   n_bphase;
    logic [23:0]            r_cbuf,     n_cbuf;
    logic [31:0]            r_run,      n_run;
    logic [CX_W-1:0]        r_col,      n_col;
    logic [CY_W-1:0]        r_row,      n_row;
    logic [PE_W-1:0]        r_pe,       n_pe;

    // pipeline
    logic              r_s1_v;
    t_pix              r_s1;
    logic              r_out_v;
    t_pix              r_out;
    logic [ADDR_W-1:0] r_out_addr;

    logic              out_free;
    logic              accept;
    logic              s1_mode;
    logic [7:0]        s1_byte;
    logic [WE_W-1:0]   w_eff;
    logic [HE_W-1:0]   h_eff;
    logic [TOT_W-1:0]  total;
    logic              ended;
    logic [2:0]        bytes_in;
    logic [31:0]       decoded;
    logic [31:0]       color;
    logic              emit;
    logic [CX_W-1:0]   col_cur;
    logic [CY_W-1:0]   row_cur;
    logic              wrap;
    t_pix              s_pix;
    logic [ADDR_W-1:0] addr;

    assign out_free      = !r_out_v || m_axis_tready;
    assign s_axis_tready = !r_s1_v || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_mode       = s_axis_tuser;
    assign s1_byte       = s_axis_tdata;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_24;
            r_rle   <= 1'b0;
            r_img_w <= DIM_W'(1);
            r_img_h <= DIM_W'(1);
            r_xrev  <= 1'b0;
            r_yrev  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PIXEL_FORMAT: r_fmt   <= i_cfg_wdata[1:0];
                REG_RLE_ENABLE:   r_rle   <= i_cfg_wdata[0];
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_wdata;
                REG_X_REVERSE:    r_xrev  <= i_cfg_wdata[0];
                REG_Y_REVERSE:    r_yrev  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---- sizes and color assembly ----
    always_comb begin
        w_eff = (r_img_w > DIM_W'(MAX_WIDTH))  ? WE_W'(MAX_WIDTH)  : WE_W'(r_img_w);
        h_eff = (r_img_h > DIM_W'(MAX_HEIGHT)) ? HE_W'(MAX_HEIGHT) : HE_W'(r_img_h);
        total = w_eff * h_eff;
        ended = {1'b0, r_pe} >= total;

        case (r_fmt)
            FMT_16:  bytes_in = 3'd2;
            FMT_24:  bytes_in = 3'd3;
            default: bytes_in = 3'd4;
        endcase

        // packed as R | G<<8 | B<<16 | A<<24
        if (r_fmt == FMT_16) begin
            decoded = {8'd0,
                       r_cbuf[4:0], 3'd0,
                       s1_byte[1:0], r_cbuf[7:5], 3'd0,
                       s1_byte[6:2], 3'd0};
        end else if (r_fmt == FMT_24) begin
            decoded = {8'd0, r_cbuf[7:0], r_cbuf[15:8], s1_byte};
        end else begin
            decoded = {s1_byte, r_cbuf[7:0], r_cbuf[15:8], r_cbuf[23:16]};
        end
    end

    // ---- packet, byte and raster state ----
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_bphase = r_bphase;
        n_cbuf   = r_cbuf;
        n_run    = r_run;
        n_col    = r_col;
        n_row    = r_row;
        n_pe     = r_pe;
        emit     = 1'b0;
        color    = decoded;
        wrap     = 1'b0;
        col_cur  = r_col;
        row_cur  = r_row;
        s_pix    = '0;

        if (ended) begin
            s_pix.error = 1'b1;
        end else if (s1_mode == MODE_PULL) begin
            if (r_phase == PH_RUN && r_left != '0) begin
                n_left = r_left - 1'b1;
                if (r_left == HDR_COUNT_W'(1)) begin
                    n_phase = PH_HEADER;
                end
                color = r_run;
                emit  = 1'b1;
            end else begin
                s_pix.error = 1'b1;
            end
        end else if (r_phase == PH_RUN) begin
            s_pix.error = 1'b1;
        end else if (r_rle && r_phase == PH_HEADER) begin
            n_left   = s1_byte[HDR_COUNT_W-1:0];
            n_phase  = s1_byte[HDR_REPEAT_BIT] ? PH_REPEAT : PH_RAW;
            n_bphase = 2'd0;
        end else if ({1'b0, r_bphase} + 3'd1 < bytes_in) begin
            case (r_bphase)
                2'd0:    n_cbuf[7:0]   = s1_byte;
                2'd1:    n_cbuf[15:8]  = s1_byte;
                default: n_cbuf[23:16] = s1_byte;
            endcase
            n_bphase = r_bphase + 2'd1;
        end else begin
            n_bphase = 2'd0;
            emit     = 1'b1;
            if (r_rle) begin
                if (r_phase == PH_REPEAT) begin
                    n_run   = decoded;
                    n_phase = (r_left != '0) ? PH_RUN : PH_HEADER;
                end else if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                end else begin
                    n_phase = PH_HEADER;
                end
            end
        end

        if (emit) begin
            // the first pixel takes the start corner from the current settings
            if (r_pe == '0) begin
                col_cur = r_xrev ? CX_W'(w_eff - 1'b1) : '0;
                row_cur = r_yrev ? CY_W'(h_eff - 1'b1) : '0;
            end

            if (r_xrev) begin
                wrap  = (col_cur == '0) || ({1'b0, col_cur} >= w_eff);
                n_col = wrap ? CX_W'(w_eff - 1'b1) : col_cur - 1'b1;
            end else begin
                wrap  = ({1'b0, col_cur} + 1'b1 >= w_eff);
                n_col = wrap ? '0 : col_cur + 1'b1;
            end

            n_row = row_cur;
            if (wrap) begin
                if (r_yrev) begin
                    if (row_cur == '0 || {1'b0, row_cur} >= h_eff) begin
                        n_row = CY_W'(h_eff - 1'b1);
                    end else begin
                        n_row = row_cur - 1'b1;
                    end
                end else begin
                    n_row = ({1'b0, row_cur} + 1'b1 >= h_eff) ? '0 : row_cur + 1'b1;
                end
            end

            n_pe = r_pe + 1'b1;
            if ({1'b0, n_pe} >= total) begin
                s_pix.done = 1'b1;
                n_phase    = PH_HEADER;
                n_left     = '0;
                n_bphase   = 2'd0;
            end

            s_pix.pixel  = 1'b1;
            s_pix.col    = col_cur;
            s_pix.row    = row_cur;
            s_pix.width  = w_eff;
            s_pix.texel4 = r_fmt[1];
            s_pix.red    = color[7:0];
            s_pix.green  = color[15:8];
            s_pix.blue   = color[23:16];
            s_pix.alpha  = color[31:24];
        end

        s_pix.run_pending = !ended && (n_phase == PH_RUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_left   <= '0;
            r_bphase <= 2'd0;
            r_cbuf   <= '0;
            r_run    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pe     <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_bphase <= n_bphase;
            r_cbuf   <= n_cbuf;
            r_run    <= n_run;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pe     <= n_pe;
        end
    end

    // ---- pipeline: decode stage, address stage, output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= s_pix;
        end
        if (out_free && r_s1_v) begin
            r_out      <= r_s1;
            r_out_addr <= addr;
        end
    end

    tpsd_addr u_addr (
        .i_pix  (r_s1),
        .o_addr (addr)
    );

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.pixel;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = {4'd0, r_out.error, r_out.run_pending,
                            r_out.alpha, r_out.blue, r_out.green, r_out.red,
                            r_out_addr};

    // ---- assertions ----
    a_run_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RUN |-> r_left != '0)
        else $error("run phase with no pixels left");

    a_err_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.error && r_out.pixel))
        else $error("refused transfer carries a pixel");

    a_done_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.done |-> r_out.pixel && !r_out.run_pending)
        else $error("image end without a final pixel");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_out_v && r_s1_v && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of the TGA pixel stream decoder. Pixel data bytes and run
// pulls go in, one per transfer. Each accepted transfer is decoded by a local
// model of the decoder, and the decoded result is queued. Every result transfer
// is compared field by field with the oldest queued result. Phases change
// format, packet coding, image size and walk direction, and vary the
// backpressure on both streams.
// ---------------------------------------------------------------------------
module testbench;
    import tpsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic             mode;
        logic [7:0]       data;
    } t_file_item;

    typedef struct packed {
        logic              pixel_valid;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              run_pending;
        logic              protocol_error;
        logic              image_done;
    } t_pixel_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    tga_pixel_stream_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_file_item file_items_q[$];
    t_pixel_out decoded_q[$];
    t_pixel_out oldest;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_request = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left = 0;

    // register copies, reset values
    logic [1:0]        fmt_now = FMT_24;
    logic              rle_now = 1'b0;
    logic [CFG_DW-1:0] width_reg = 1;
    logic [CFG_DW-1:0] height_reg = 1;
    logic              xrev_now = 1'b0;
    logic              yrev_now = 1'b0;

    // decoder state
    t_phase      pkt_phase = PH_HEADER;
    int          pkt_left = 0;
    int          color_phase = 0;
    logic [23:0] color_acc = '0;
    logic [31:0] run_rgba = '0;
    longint      cur_col = 0;
    longint      cur_row = 0;
    longint      pixels_out = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint eff_width();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic longint eff_height();
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function automatic int color_bytes(input logic [1:0] fmt);
        return (fmt == FMT_16) ? 2 : ((fmt == FMT_24) ? 3 : 4);
    endfunction

    // color packed as {A, B, G, R}
    function automatic logic [31:0] assemble_color(input logic [7:0] last);
        logic [15:0] word;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        word = {last, color_acc[7:0]};
        a = '0;
        if (fmt_now == FMT_16) begin
            r = {word[14:10], 3'b000};
            g = {word[9:5], 3'b000};
            b = {word[4:0], 3'b000};
        end else begin
            b = color_acc[7:0];
            g = color_acc[15:8];
            if (fmt_now == FMT_24) begin
                r = last;
            end else begin
                r = color_acc[23:16];
                a = last;
            end
        end
        return {a, b, g, r};
    endfunction

    function automatic t_pixel_out place_pixel(input logic [31:0] color, input t_pixel_out res);
        longint w;
        longint h;
        longint addr;
        logic   wrap;
        w = eff_width();
        h = eff_height();
        // the start corner is latched on the first pixel of the image
        if (pixels_out == 0) begin
            cur_col = (xrev_now && w > 0) ? w - 1 : 0;
            cur_row = (yrev_now && h > 0) ? h - 1 : 0;
        end
        addr = (cur_col + w * cur_row) * ((fmt_now == FMT_16 || fmt_now == FMT_24) ? 3 : 4);
        res.pixel_valid  = 1'b1;
        res.byte_address = addr[ADDR_W-1:0];
        res.red          = color[7:0];
        res.green        = color[15:8];
        res.blue         = color[23:16];
        res.alpha        = color[31:24];
        if (xrev_now) begin
            wrap = (cur_col == 0 || cur_col >= w);
            cur_col = wrap ? ((w > 0) ? w - 1 : 0) : cur_col - 1;
        end else begin
            wrap = (cur_col + 1 >= w);
            cur_col = wrap ? 0 : cur_col + 1;
        end
        if (wrap) begin
            if (yrev_now) begin
                if (cur_row == 0 || cur_row >= h) cur_row = (h > 0) ? h - 1 : 0;
                else cur_row = cur_row - 1;
            end else begin
                cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
            end
        end
        pixels_out++;
        if (pixels_out >= w * h) begin
            res.image_done = 1'b1;
            pkt_phase = PH_HEADER;
            pkt_left = 0;
            color_phase = 0;
        end
        return res;
    endfunction

    function automatic t_pixel_out decode_item(input logic mode, input logic [7:0] b);
        t_pixel_out  res;
        logic [31:0] color;
        res = '0;
        if (pixels_out >= eff_width() * eff_height()) begin
            res.protocol_error = 1'b1;
            return res;
        end
        if (mode == MODE_PULL) begin
            if (pkt_phase == PH_RUN && pkt_left > 0) begin
                pkt_left--;
                if (pkt_left == 0) pkt_phase = PH_HEADER;
                res = place_pixel(run_rgba, res);
            end else begin
                res.protocol_error = 1'b1;
            end
        end else if (pkt_phase == PH_RUN) begin
            res.protocol_error = 1'b1;
        end else if (rle_now && pkt_phase == PH_HEADER) begin
            pkt_left = b[HDR_COUNT_W-1:0];
            pkt_phase = b[HDR_REPEAT_BIT] ? PH_REPEAT : PH_RAW;
            color_phase = 0;
        end else if (color_phase + 1 < color_bytes(fmt_now)) begin
            color_acc[color_phase*8 +: 8] = b;
            color_phase++;
        end else begin
            color = assemble_color(b);
            color_phase = 0;
            if (!rle_now) begin
                res = place_pixel(color, res);
            end else if (pkt_phase == PH_REPEAT) begin
                run_rgba = color;
                pkt_phase = (pkt_left > 0) ? PH_RUN : PH_HEADER;
                res = place_pixel(color, res);
            end else begin
                if (pkt_left > 0) pkt_left--;
                else pkt_phase = PH_HEADER;
                res = place_pixel(color, res);
            end
        end
        res.run_pending = (pkt_phase == PH_RUN);
        return res;
    endfunction

    // driver: hold data while stalled, otherwise load the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (file_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= file_items_q[0].mode;
                s_axis_tdata  <= file_items_q[0].data;
                void'(file_items_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            decoded_q.push_back(decode_item(s_axis_tuser, s_axis_tdata));
    end

    // receiver: one long hold-off when requested, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            m_axis_tready <= 1'b0;
            hold_left <= 400;
            hold_taken <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            if (mismatches < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $error("result transfer with no pixel pending: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                oldest = decoded_q.pop_front();
                check_field("pixel_valid", oldest.pixel_valid, m_axis_tuser);
                check_field("byte_address", oldest.byte_address, m_axis_tdata[25:0]);
                check_field("red", oldest.red, m_axis_tdata[33:26]);
                check_field("green", oldest.green, m_axis_tdata[41:34]);
                check_field("blue", oldest.blue, m_axis_tdata[49:42]);
                check_field("alpha", oldest.alpha, m_axis_tdata[57:50]);
                check_field("run_pending", oldest.run_pending, m_axis_tdata[58]);
                check_field("protocol_error", oldest.protocol_error, m_axis_tdata[59]);
                check_field("image_done", oldest.image_done, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void push_item(input logic mode, input logic [7:0] b);
        file_items_q.push_back('{mode: mode, data: b});
    endfunction

    function automatic logic [7:0] header(input bit repeat_pkt, input int count);
        logic [7:0] h;
        h = '0;
        h[HDR_REPEAT_BIT] = repeat_pkt;
        h[HDR_COUNT_W-1:0] = count[HDR_COUNT_W-1:0];
        return h;
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT: fmt_now = value[1:0];
            REG_RLE_ENABLE:   rle_now = value[0];
            REG_IMAGE_WIDTH:  width_reg = value[CFG_DW-1:0];
            REG_IMAGE_HEIGHT: height_reg = value[CFG_DW-1:0];
            REG_X_REVERSE:    xrev_now = value[0];
            REG_Y_REVERSE:    yrev_now = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] fmt, input bit rle, input int w, input int h,
                             input bit xr, input bit yr);
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_RLE_ENABLE, rle);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_X_REVERSE, xr);
        write_reg(REG_Y_REVERSE, yr);
    endtask

    // wait until every sent item has come back, then let the pipeline settle
    task automatic drain();
        while (file_items_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(input int sel);
        case (sel)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    // one packet (run-length mode) or one pixel's bytes; returns items queued
    function automatic int push_packet(input bit rle, input int nbytes);
        bit repeat_pkt;
        int count;
        if (!rle) begin
            repeat (nbytes) push_item(MODE_DATA, 8'($urandom_range(255)));
            return nbytes;
        end
        repeat_pkt = 1'($urandom_range(1));
        if ($urandom_range(19) == 0)
            count = repeat_pkt ? $urandom_range(127) : $urandom_range(31);
        else
            count = $urandom_range(7);
        push_item(MODE_DATA, header(repeat_pkt, count));
        if (repeat_pkt) begin
            repeat (nbytes) push_item(MODE_DATA, 8'($urandom_range(255)));
            repeat (count) push_item(MODE_PULL, 8'($urandom_range(255)));
            return 1 + nbytes + count;
        end
        repeat ((count + 1) * nbytes) push_item(MODE_DATA, 8'($urandom_range(255)));
        return 1 + (count + 1) * nbytes;
    endfunction

    // h < 0 sizes the image so that it ends near the end of the phase
    task automatic run_phase(input logic [1:0] fmt, input bit rle, input int w, input int h,
                             input bit xr, input bit yr, input int n_items, input int idling,
                             input bit hold_off);
        int     nbytes;
        int     made;
        int     rows;
        longint ew;
        drain();
        nbytes = color_bytes(fmt);
        rows = h;
        if (h < 0) begin
            ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
            rows = (ew == 0) ? 1 : int'((pixels_out + n_items / nbytes + ew - 1) / ew);
            if (rows > MAX_HEIGHT) rows = MAX_HEIGHT;
            if (rows < 1) rows = 1;
        end
        configure(fmt, rle, w, rows, xr, yr);
        set_idling(idling);
        hold_request = hold_off;
        // finish a run left pending so that new bytes are not all refused
        if (pkt_phase == PH_RUN)
            repeat (pkt_left) push_item(MODE_PULL, 8'($urandom_range(255)));
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(99) < 85) begin
                made += push_packet(rle, nbytes);
            end else begin
                push_item($urandom_range(1) ? MODE_PULL : MODE_DATA, 8'($urandom_range(255)));
                made++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 image walked from the bottom right corner, 16-bit, packet coded
        configure(FMT_16, 1'b1, 3, 2, 1'b1, 1'b1);
        set_idling(0);
        push_item(MODE_PULL, 8'hA5);             // nothing pending
        push_item(MODE_DATA, header(1'b1, 2));
        push_item(MODE_DATA, 8'h00);
        push_item(MODE_DATA, 8'hFF);
        push_item(MODE_DATA, 8'h55);             // refused while the run is pending
        push_item(MODE_PULL, 8'h00);
        push_item(MODE_PULL, 8'hFF);
        push_item(MODE_PULL, 8'h00);             // run exhausted
        push_item(MODE_DATA, header(1'b0, 0));
        push_item(MODE_DATA, 8'hFF);
        push_item(MODE_DATA, 8'h7F);
        push_item(MODE_DATA, header(1'b1, 5));   // run longer than the rest of the image
        push_item(MODE_DATA, 8'h12);
        push_item(MODE_DATA, 8'h34);
        push_item(MODE_PULL, 8'h00);             // final pixel
        push_item(MODE_PULL, 8'h00);             // after the end
        push_item(MODE_DATA, 8'h80);

        run_phase(FMT_24, 1'b0, 7, -1, 1'b0, 1'b0, 120, 0, 1'b0);
        run_phase(FMT_32, 1'b1, 5, -1, 1'b1, 1'b0, 150, 1, 1'b0);
        run_phase(FMT_16, 1'b1, 1, -1, 1'b0, 1'b1, 150, 2, 1'b0);
        run_phase(2'd3, 1'b1, MAX_WIDTH, MAX_HEIGHT, 1'b1, 1'b1, 120, 3, 1'b0);
        run_phase(FMT_24, 1'b1, 8191, -1, 1'b0, 1'b0, 120, 0, 1'b1);
        run_phase(FMT_16, 1'b0, 0, 0, 1'b0, 1'b0, 25, 1, 1'b1);
        run_phase(FMT_32, 1'b0, 9, 8191, 1'b0, 1'b1, 100, 2, 1'b1);
        run_phase(FMT_24, 1'b1, 13, -1, 1'b1, 1'b1, 150, 3, 1'b1);
        run_phase(FMT_16, 1'b1, 2, -1, 1'b0, 1'b0, 100, 0, 1'b1);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/tpsd_pkg.sv
sv/tpsd_addr.sv
sv/tga_pixel_stream_decoder.sv
dv/testbench.sv
